// File: rtl/hrl_pkg.sv
// hrl_pkg: shared types, character codes and the digit mapping of the
// hex record line decoder. No dependencies.
package hrl_pkg;

  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] LETTER_OFFSET = 8'h37;
  localparam logic [7:0] INDEX_MAX     = 8'hFF;

  localparam logic [2:0] ROLE_COUNT     = 3'd0;
  localparam logic [2:0] ROLE_ADDR_HIGH = 3'd1;
  localparam logic [2:0] ROLE_ADDR_LOW  = 3'd2;
  localparam logic [2:0] ROLE_TYPE      = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd4;
  localparam logic [2:0] ROLE_VERDICT   = 3'd5;

  typedef enum logic {
    OP_DIGIT,
    OP_EOL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // '0'..'9' map to c-0x30, everything else wraps c-0x37 mod 256
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic is_dec;
    is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    return is_dec ? (c - CHAR_ZERO) : (c - LETTER_OFFSET);
  endfunction

endpackage

// File: rtl/hrl_if.sv
// Channel interfaces of the hex record line decoder: character words in,
// result words out. Depends on nothing.
interface hrl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;

  modport source (output valid, character, end_of_line, input ready);
  modport sink (input valid, character, end_of_line, output ready);
endinterface

interface hrl_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] role;
  logic [7:0] byte_index;
  logic       record_ok;
  logic       last;

  modport source (output valid, byte_value, role, byte_index, record_ok, last,
                  input ready);
  modport sink (input valid, byte_value, role, byte_index, record_ok, last,
                output ready);
endinterface

// File: rtl/hrl_front.sv
// Front end: accepts character words, drops separators, maps digits.
// Depends on hrl_pkg and hrl_char_if.
module hrl_front import hrl_pkg::*; (
  hrl_char_if.sink char_in,
  input  logic     q_full,
  output push_t    push
);

  logic skip;

  assign skip         = (char_in.character == CHAR_COLON) ||
                        (char_in.character == CHAR_CR);
  assign char_in.ready = !q_full;

  always_comb begin
    push.valid       = char_in.valid && !q_full && (char_in.end_of_line || !skip);
    push.entry.op    = char_in.end_of_line ? OP_EOL : OP_DIGIT;
    push.entry.value = digit_value(char_in.character);
  end

endmodule

// File: rtl/hrl_queue.sv
// Short register queue between front and back end.
// Depends on hrl_pkg.
module hrl_queue import hrl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   full,
  output logic   q_valid,
  output entry_t q_entry,
  input  logic   pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hrl_back.sv
// Back end: pairs digits into bytes, keeps the line checksum and drives
// the result register. Depends on hrl_pkg and hrl_result_if.
module hrl_back import hrl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  entry_t   q_entry,
  output logic     pop,
  hrl_result_if.source rec_out
);

  logic       nibble_pending, nibble_pending_next;
  logic [3:0] high_digit, high_digit_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] last_byte, last_byte_next;
  logic       line_has_chars, line_has_chars_next;

  logic       emit;
  logic [7:0] res_value, res_index;
  logic [2:0] res_role;
  logic       res_ok, res_last;
  logic [7:0] new_byte;

  // advance when the result register is free or being drained
  assign pop      = q_valid && (!rec_out.valid || rec_out.ready);
  assign new_byte = {high_digit, 4'h0} + q_entry.value;

  always_comb begin
    nibble_pending_next = nibble_pending;
    high_digit_next     = high_digit;
    bytes_seen_next     = bytes_seen;
    running_sum_next    = running_sum;
    last_byte_next      = last_byte;
    line_has_chars_next = line_has_chars;
    emit      = 1'b0;
    res_value = new_byte;
    res_role  = (bytes_seen < 8'd4) ? bytes_seen[2:0] : ROLE_PAYLOAD;
    res_index = bytes_seen;
    res_ok    = 1'b0;
    res_last  = 1'b0;
    unique case (q_entry.op)
      OP_EOL: begin
        emit      = line_has_chars;
        res_value = (bytes_seen != '0) ? last_byte : 8'h00;
        res_role  = ROLE_VERDICT;
        res_ok    = (bytes_seen != '0) && (running_sum == '0);
        res_last  = 1'b1;
        nibble_pending_next = 1'b0;
        high_digit_next     = '0;
        bytes_seen_next     = '0;
        running_sum_next    = '0;
        last_byte_next      = '0;
        line_has_chars_next = 1'b0;
      end
      OP_DIGIT: begin
        line_has_chars_next = 1'b1;
        if (!nibble_pending) begin
          high_digit_next     = q_entry.value[3:0];
          nibble_pending_next = 1'b1;
        end else begin
          emit                = 1'b1;
          nibble_pending_next = 1'b0;
          high_digit_next     = '0;
          running_sum_next    = running_sum + new_byte;
          last_byte_next      = new_byte;
          if (bytes_seen != INDEX_MAX) begin
            bytes_seen_next = bytes_seen + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_pending <= 1'b0;
      high_digit     <= '0;
      bytes_seen     <= '0;
      running_sum    <= '0;
      last_byte      <= '0;
      line_has_chars <= 1'b0;
      rec_out.valid  <= 1'b0;
    end else begin
      if (pop) begin
        nibble_pending <= nibble_pending_next;
        high_digit     <= high_digit_next;
        bytes_seen     <= bytes_seen_next;
        running_sum    <= running_sum_next;
        last_byte      <= last_byte_next;
        line_has_chars <= line_has_chars_next;
        rec_out.valid  <= emit;
      end else if (rec_out.ready) begin
        rec_out.valid <= 1'b0;
      end
    end
  end

  // payload holds until the next popped word overwrites it
  always_ff @(posedge clk) begin
    if (pop) begin
      rec_out.byte_value <= res_value;
      rec_out.role       <= res_role;
      rec_out.byte_index <= res_index;
      rec_out.record_ok  <= res_ok;
      rec_out.last       <= res_last;
    end
  end

endmodule

// File: rtl/hex_record_line_decoder.sv
// Top level of the hex record line decoder: front end, queue, back end.
// Depends on hrl_pkg, hrl_if, hrl_front, hrl_queue and hrl_back.
//
//   channel   dir  word contents
//   char_in   in   character[7:0], end_of_line
//   rec_out   out  byte_value[7:0], role[2:0], byte_index[7:0], record_ok, last
//
// One character word is taken per cycle while the queue is not full; a word
// that yields a result passes a queue slot, then the result register.
// The back end processes one queued word per cycle while the result register
// is free or being drained; it adds each byte into an 8-bit running sum.
// A stall on rec_out fills the queue (QUEUE_DEPTH words); char_in.ready
// drops only when the queue is full. Synchronous reset clears all line state.
module hex_record_line_decoder import hrl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic clk,
  input logic rst,
  hrl_char_if.sink     char_in,
  hrl_result_if.source rec_out
);

  push_t  push;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  hrl_front u_front (
    .char_in (char_in),
    .q_full  (q_full),
    .push    (push)
  );

  hrl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop)
  );

  hrl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .rec_out (rec_out)
  );

endmodule

// File: sim/hrl_line_check.sv
`timescale 1ns / 100ps
// hrl_line_check: watches both channels of the hex record line decoder,
// predicts each result word from the character stream and compares it.
// Depends on hrl_pkg and hrl_if.
module hrl_line_check import hrl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  hrl_char_if   char_in,
  hrl_result_if rec_out,
  output int    failures,
  output int    awaited
);

  typedef struct packed {
    logic [7:0] byte_value;
    logic [2:0] role;
    logic [7:0] byte_index;
    logic       record_ok;
    logic       last;
  } rec_word_t;

  // line state of the predictor
  logic       half_pending;
  logic [3:0] hi_nib;
  logic [7:0] byte_count;
  logic [7:0] line_sum;
  logic [7:0] recent_byte;
  logic       seen_char;

  rec_word_t  due_words[$];

  initial failures = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    failures++;
  endtask

  task automatic clear_line_state();
    half_pending = 1'b0;
    hi_nib       = '0;
    byte_count   = '0;
    line_sum     = '0;
    recent_byte  = '0;
    seen_char    = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eol,
                             output bit made, output rec_word_t w);
    logic [7:0] v;
    logic [7:0] b;
    logic [7:0] idx;
    made = 1'b0;
    w    = '0;
    if (eol) begin
      // empty line: no verdict, state is cleared anyway
      if (seen_char) begin
        made         = 1'b1;
        w.byte_value = (byte_count != 8'd0) ? recent_byte : 8'h00;
        w.role       = ROLE_VERDICT;
        w.byte_index = byte_count;
        w.record_ok  = (byte_count != 8'd0) && (line_sum == 8'h00);
        w.last       = 1'b1;
      end
      clear_line_state();
    end else if (c != CHAR_COLON && c != CHAR_CR) begin
      seen_char = 1'b1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) v = c - CHAR_ZERO;
      else v = c - LETTER_OFFSET;
      if (!half_pending) begin
        hi_nib       = v[3:0];
        half_pending = 1'b1;
      end else begin
        b            = {hi_nib, 4'h0} + v;
        idx          = byte_count;
        half_pending = 1'b0;
        hi_nib       = '0;
        line_sum     = line_sum + b;
        recent_byte  = b;
        // hold the count at its top, the sum keeps taking bytes
        if (byte_count != INDEX_MAX) byte_count = byte_count + 8'd1;
        made         = 1'b1;
        w.byte_value = b;
        w.byte_index = idx;
        case (idx)
          8'd0:    w.role = ROLE_COUNT;
          8'd1:    w.role = ROLE_ADDR_HIGH;
          8'd2:    w.role = ROLE_ADDR_LOW;
          8'd3:    w.role = ROLE_TYPE;
          default: w.role = ROLE_PAYLOAD;
        endcase
      end
    end
  endtask

  always @(posedge clk) begin : watch
    rec_word_t got;
    rec_word_t want;
    rec_word_t next_word;
    bit        made;
    if (rst) begin
      clear_line_state();
      due_words.delete();
      awaited <= 0;
    end else begin
      if (rec_out.valid && rec_out.ready) begin
        got = '{rec_out.byte_value, rec_out.role, rec_out.byte_index,
                rec_out.record_ok, rec_out.last};
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word, byte_value", got.byte_value, 8'h00);
        end else begin
          want = due_words.pop_front();
          if (got.byte_value !== want.byte_value)
            report_mismatch("byte_value", got.byte_value, want.byte_value);
          if (got.role !== want.role)
            report_mismatch("role", 8'(got.role), 8'(want.role));
          if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
          if (got.record_ok !== want.record_ok)
            report_mismatch("record_ok", 8'(got.record_ok), 8'(want.record_ok));
          if (got.last !== want.last)
            report_mismatch("last", 8'(got.last), 8'(want.last));
        end
      end
      if (char_in.valid && char_in.ready) begin
        decode_char(char_in.character, char_in.end_of_line, made, next_word);
        if (made) due_words.push_back(next_word);
      end
      awaited <= due_words.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: drives hex record lines into the decoder, stalls the result side at
// random and gives the verdict. Depends on hrl_pkg, hrl_if, hrl_line_check.
module tb;
  import hrl_pkg::*;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam int ITEMS_PER_PHASE = 200;

  logic clk;
  logic rst;
  int   failures;
  int   awaited;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;

  hrl_char_if   char_in();
  hrl_result_if rec_out();

  hex_record_line_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .rec_out (rec_out)
  );

  hrl_line_check line_check (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .rec_out  (rec_out),
    .failures (failures),
    .awaited  (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    rec_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + n : CHAR_A + n - 8'd10;
  endfunction

  task automatic send_word(input logic [7:0] c, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid       <= 1'b1;
    char_in.character   <= c;
    char_in.end_of_line <= eol;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_hex(input logic [7:0] b);
    send_word(hex_char(b[7:4]), 1'b0);
    send_word(hex_char(b[3:0]), 1'b0);
  endtask

  // well-formed record with n data bytes; corrupt breaks the checksum
  task automatic send_record(input bit corrupt, input int n);
    logic [7:0] body[$];
    logic [7:0] total;
    logic [7:0] flip;
    logic [7:0] sum_byte;
    body.push_back(n[7:0]);
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(8'($urandom_range(0, 5)));
    repeat (n) body.push_back(8'($urandom));
    total = '0;
    foreach (body[i]) total = total + body[i];
    flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
    sum_byte = (8'h00 - total) ^ flip;
    body.push_back(sum_byte);
    if ($urandom_range(0, 9) != 0) send_word(CHAR_COLON, 1'b0);
    foreach (body[i]) send_hex(body[i]);
    if ($urandom_range(0, 1) != 0) send_word(CHAR_CR, 1'b0);
    send_word(8'($urandom), 1'b1);
  endtask

  task automatic send_noise_line();
    int len;
    len = $urandom_range(0, 15);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       send_word(8'($urandom), 1'b0);
        1:       send_word(($urandom_range(0, 1) != 0) ? CHAR_COLON : CHAR_CR, 1'b0);
        default: send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
      endcase
    end
    send_word(8'($urandom), 1'b1);
  endtask

  // drop valid and hold until every predicted word has come back
  task automatic drain();
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  initial begin
    rst                 = 1'b1;
    char_in.valid       = 1'b0;
    char_in.character   = '0;
    char_in.end_of_line = 1'b0;
    rec_out.ready       = 1'b0;
    send_idle_pct       = 22;
    recv_stall_pct      = 60;
    items_sent          = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty lines, one-character line, a good end-of-file record,
    // odd digit count, extreme character codes
    send_word(8'hFF, 1'b1);
    send_text(":\r");
    send_word(8'h00, 1'b1);
    send_text("5");
    send_word(8'h5A, 1'b1);
    send_text(":00000001FF\r");
    send_word(8'hA5, 1'b1);
    send_text("ABC");
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 22;
          recv_stall_pct = 60;
        end
        1: begin
          send_idle_pct  = 60;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // long line: index saturates while the sum keeps running
          send_record(1'b0, 252);
        end
      endcase
      while (items_sent < ITEMS_PER_PHASE * (phase + 1)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: send_record(1'b0,
              ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8));
          7:       send_record(1'b1, $urandom_range(0, 8));
          default: send_noise_line();
        endcase
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
